FILE: hdl/assert_macros.svh
// Assertion helpers included by the resampler top.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequence in the same cycle as the condition.
`define AER_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check the consequence in the cycle after the condition.
`define AER_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/aer_pkg.sv
package aer_pkg;

	// Block geometry
	localparam int RING_DEPTH = 512;
	localparam int BLOCK_LEN  = 64;
	localparam int FADE_LEN   = 16;

	localparam int ADDR_W    = $clog2(RING_DEPTH);
	localparam int BLK_W     = $clog2(BLOCK_LEN);
	localparam int FADE_W    = $clog2(FADE_LEN + 1);
	localparam int CNT_W     = 32;
	localparam int SAMPLE_W  = 16;
	localparam int FRAC_W    = 16;
	localparam int STEP_W    = FRAC_W + 1;
	localparam int TL_W      = 9;
	localparam int DB_W      = 8;
	localparam int MD_W      = 11;
	localparam int CFG_W     = 11;
	localparam int DEV_W     = ((ADDR_W > MD_W) ? ADDR_W : MD_W) + 2;
	localparam int FULL_MARK = RING_DEPTH * 3 / 4;

	// Shared multiplier and divide-by-(FADE_LEN+1) reciprocal
	localparam int MUL_W     = 28;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int ACC_W     = SAMPLE_W + FADE_W + 1;
	localparam int DIV_SHIFT = 26;
	localparam int FADE_DIV  = FADE_LEN + 1;
	localparam logic [DIV_SHIFT-1:0] RECIP =
		DIV_SHIFT'((2**DIV_SHIFT + FADE_DIV - 1) / FADE_DIV);

	localparam logic [STEP_W-1:0]   FRAC_ONE   = STEP_W'(1 << FRAC_W);
	localparam logic [FADE_W:0]     FADE_DIV_V = (FADE_W + 1)'(FADE_DIV);
	localparam logic [FADE_W-1:0]   FADE_INIT  = FADE_W'(FADE_LEN);
	localparam logic [BLK_W-1:0]    LAST_IDX   = BLK_W'(BLOCK_LEN - 1);
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

	localparam logic [TL_W-1:0] TARGET_LAG_RST    = TL_W'(96);
	localparam logic [DB_W-1:0] DEAD_BAND_RST     = DB_W'(48);
	localparam logic [MD_W-1:0] MAX_DEVIATION_RST = MD_W'(64);

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_READ  = 1'b1
	} aer_cmd_t;

	typedef enum logic [1:0] {
		REG_TARGET_LAG    = 2'd0,
		REG_DEAD_BAND     = 2'd1,
		REG_MAX_DEVIATION = 2'd2
	} aer_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FILL,
		S_STEP,
		S_RD_A,
		S_RD_B,
		S_MUL,
		S_INTERP,
		S_F1,
		S_F2,
		S_F3,
		S_F4,
		S_F5,
		S_EMIT
	} aer_state_t;

endpackage

FILE: hdl/audio_elastic_resampler_top.sv
// Elastic mono resampler between a producer and a consumer clocked on clk.
// Input stream: each transaction is one command. tuser = 0 writes a stereo
// pair from tdata; the pair is averaged to mono and appended to a
// 512-entry ring. tuser = 1 requests one block of 64 output samples.
// Output stream: one transaction per sample; tuser flags underrun (bit 0)
// and a block that began with a resync (bit 1); tlast marks sample 64.
// A write leaves the sequencer idle, so the input stays ready.
// A read runs the fill check and the rate step, then each sample runs on
// one shared multiplier: an interpolated sample takes two ring reads on
// the single memory port, a multiply, an add and the load of the output
// register; an underrun repeat only loads the output register; while the
// crossfade runs, two weight products and a reciprocal multiply come
// before the load. The input is
// not ready until the last sample of the block sits in the output register.
// A stall on the output holds the sequencer in its load step; the output
// register holds its sample until the consumer takes it.
// Reset clears pointers, crossfade state and registers to their defaults.
// The ring needs no clearing pass: entries not yet written read as zero,
// decided from the write count and a sticky full mark.
// Configuration writes are taken on any edge with cfg_we high; make them
// only while no read block is in progress.
`include "assert_macros.svh"

module audio_elastic_resampler_top
	import aer_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] left_sample, [31:16] right_sample
	input  logic        s_axis_tuser,  // [0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [15:0] out_sample
	output logic [1:0]  m_axis_tuser,  // [0] underrun, [1] resynced
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [10:0] cfg_data
);

	aer_state_t state_q, state_d;

	// Configuration
	logic [TL_W-1:0] tl_q;
	logic [DB_W-1:0] db_q;
	logic [MD_W-1:0] md_q;

	// Ring and pointers
	logic [SAMPLE_W-1:0] ring [RING_DEPTH];
	logic [CNT_W-1:0]    wr_cnt_q;
	logic [CNT_W-1:0]    rd_cnt_q;
	logic [FRAC_W-1:0]   rd_frac_q;
	logic                full_q;

	// Persistent output state
	logic [SAMPLE_W-1:0] last_out_q;
	logic [SAMPLE_W-1:0] fade_from_q;
	logic [FADE_W-1:0]   fade_rem_q;
	logic                resync_q;
	logic [BLK_W-1:0]    sample_cnt_q;

	// Per-block and per-sample working registers
	logic signed [DEV_W-1:0]    dev_q;
	logic [STEP_W-1:0]          step_q;
	logic [SAMPLE_W-1:0]        rd_data_q;
	logic                       rd_ok_q;
	logic [SAMPLE_W-1:0]        a_q;
	logic signed [SAMPLE_W:0]   m_q;
	logic                       under_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic [ACC_W-1:0]           absx_q;
	logic                       neg_q;

	// Output register
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_sample_q;
	logic                out_under_q;
	logic                out_resync_q;
	logic                out_last_q;

	// Combinational control
	logic                     in_accept;
	logic                     wr_en;
	logic                     ram_rd_en;
	logic [ADDR_W-1:0]        ram_rd_addr;
	logic                     rd_ok_c;
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic                     out_load;
	logic                     out_last_c;

	// Datapath helpers
	logic signed [SAMPLE_W:0]   pair_sum_c;
	logic [SAMPLE_W-1:0]        mono_c;
	logic signed [CNT_W-1:0]    fill_c;
	logic signed [CNT_W-1:0]    dist_c;
	logic                       resync_c;
	logic                       ahead_ok_c;
	logic signed [DEV_W-1:0]    fill_dev_c;
	logic signed [DEV_W-1:0]    db_s;
	logic signed [DEV_W-1:0]    md_s;
	logic signed [DEV_W-1:0]    band_c;
	logic signed [DEV_W-1:0]    clamp_c;
	logic signed [DEV_W-1:0]    half_c;
	logic signed [STEP_W:0]     step_c;
	logic [FRAC_W+1:0]          frac_sum_c;
	logic signed [SAMPLE_W:0]   diff_c;
	logic signed [SAMPLE_W:0]   interp_c;
	logic [FADE_W:0]            new_wgt_c;
	logic signed [ACC_W-1:0]    mix_c;
	logic [SAMPLE_W:0]          quot_c;
	logic [SAMPLE_W-1:0]        sat_c;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign wr_en     = in_accept && (s_axis_tuser == CMD_WRITE);

	// Stereo to mono, truncated toward zero
	assign pair_sum_c = $signed({s_axis_tdata[15], s_axis_tdata[15:0]})
		+ $signed({s_axis_tdata[31], s_axis_tdata[31:16]});
	assign mono_c = SAMPLE_W'(pair_sum_c >>> 1)
		+ {{(SAMPLE_W-1){1'b0}}, pair_sum_c[SAMPLE_W] & pair_sum_c[0]};

	// Fill check: resync when the ring is nearly full or short of one block
	assign fill_c   = $signed(wr_cnt_q - rd_cnt_q);
	assign resync_c = (fill_c >= CNT_W'(FULL_MARK)) || (fill_c < CNT_W'(BLOCK_LEN));
	assign fill_dev_c = $signed({{(DEV_W-ADDR_W){1'b0}}, fill_c[ADDR_W-1:0]})
		- $signed({{(DEV_W-TL_W){1'b0}}, tl_q});

	// Rate step: deadband, clamp, halve toward zero
	assign db_s = $signed({{(DEV_W-DB_W){1'b0}}, db_q});
	assign md_s = $signed({{(DEV_W-MD_W){1'b0}}, md_q});

	always_comb begin
		if (dev_q > db_s) begin
			band_c = dev_q - db_s;
		end else if (dev_q < -db_s) begin
			band_c = dev_q + db_s;
		end else begin
			band_c = '0;
		end
		if (band_c > md_s) begin
			clamp_c = md_s;
		end else if (band_c < -md_s) begin
			clamp_c = -md_s;
		end else begin
			clamp_c = band_c;
		end
		half_c = (clamp_c >>> 1)
			+ $signed({{(DEV_W-1){1'b0}}, clamp_c[DEV_W-1] & clamp_c[0]});
		step_c = $signed({1'b0, FRAC_ONE})
			+ $signed({{(STEP_W+1-DEV_W){half_c[DEV_W-1]}}, half_c});
	end

	// Underrun test: at least two samples ahead of the read point
	assign dist_c     = $signed(wr_cnt_q - rd_cnt_q);
	assign ahead_ok_c = dist_c > 32'sd1;

	assign frac_sum_c = {2'b00, rd_frac_q} + {1'b0, step_q};
	assign diff_c     = $signed({rd_ok_q ? rd_data_q[SAMPLE_W-1] : 1'b0,
		rd_ok_q ? rd_data_q : '0}) - $signed({a_q[SAMPLE_W-1], a_q});
	assign interp_c   = $signed({a_q[SAMPLE_W-1], a_q})
		+ $signed(prod_q[FRAC_W+SAMPLE_W:FRAC_W]);

	assign new_wgt_c = FADE_DIV_V - {1'b0, fade_rem_q};
	assign mix_c     = acc_q + $signed(prod_q[ACC_W-1:0]);
	assign quot_c    = prod_q[DIV_SHIFT+SAMPLE_W:DIV_SHIFT];

	// Saturate to 16 bits
	always_comb begin
		if (m_q[SAMPLE_W] != m_q[SAMPLE_W-1]) begin
			sat_c = m_q[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
		end else begin
			sat_c = m_q[SAMPLE_W-1:0];
		end
	end

	assign out_last_c = (sample_cnt_q == LAST_IDX);

	// Entry reads as zero until its first write
	assign rd_ok_c = full_q || (ram_rd_addr < wr_cnt_q[ADDR_W-1:0]);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept && (s_axis_tuser == CMD_READ)) begin
					state_d = S_FILL;
				end
			end
			S_FILL: state_d = S_STEP;
			S_STEP: state_d = S_RD_A;
			S_RD_A: begin
				if (ahead_ok_c) begin
					state_d = S_RD_B;
				end else if (fade_rem_q != '0) begin
					state_d = S_F1;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_RD_B: state_d = S_MUL;
			S_MUL:  state_d = S_INTERP;
			S_INTERP: state_d = (fade_rem_q != '0) ? S_F1 : S_EMIT;
			S_F1: state_d = S_F2;
			S_F2: state_d = S_F3;
			S_F3: state_d = S_F4;
			S_F4: state_d = S_F5;
			S_F5: state_d = S_EMIT;
			S_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = out_last_c ? S_IDLE : S_RD_A;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: ready, memory port, multiplier operands, output load
	always_comb begin
		s_axis_tready = 1'b0;
		ram_rd_en     = 1'b0;
		ram_rd_addr   = rd_cnt_q[ADDR_W-1:0];
		mul_a         = '0;
		mul_b         = '0;
		out_load      = 1'b0;
		unique case (state_q)
			S_IDLE: s_axis_tready = 1'b1;
			S_RD_A: ram_rd_en = ahead_ok_c;
			S_RD_B: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = rd_cnt_q[ADDR_W-1:0] + ADDR_W'(1);
			end
			S_MUL: begin
				mul_a = MUL_W'(diff_c);
				mul_b = MUL_W'($signed({1'b0, rd_frac_q}));
			end
			S_F1: begin
				mul_a = MUL_W'(m_q);
				mul_b = MUL_W'($signed({1'b0, new_wgt_c}));
			end
			S_F2: begin
				mul_a = MUL_W'($signed(fade_from_q));
				mul_b = MUL_W'($signed({1'b0, fade_rem_q}));
			end
			S_F4: begin
				mul_a = MUL_W'($signed({1'b0, absx_q}));
				mul_b = MUL_W'($signed({1'b0, RECIP}));
			end
			S_EMIT: out_load = !out_valid_q || m_axis_tready;
			default: begin
			end
		endcase
	end

	// Ring: one write or one read per cycle, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring[wr_cnt_q[ADDR_W-1:0]] <= mono_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_rd_en) begin
			rd_data_q <= ring[ram_rd_addr];
			rd_ok_q   <= rd_ok_c;
		end
	end

	// Shared multiplier, product registered
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Control state and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tl_q         <= TARGET_LAG_RST;
			db_q         <= DEAD_BAND_RST;
			md_q         <= MAX_DEVIATION_RST;
			wr_cnt_q     <= '0;
			rd_cnt_q     <= '0;
			rd_frac_q    <= '0;
			full_q       <= 1'b0;
			last_out_q   <= '0;
			fade_from_q  <= '0;
			fade_rem_q   <= '0;
			resync_q     <= 1'b0;
			sample_cnt_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_addr)
					REG_TARGET_LAG:    tl_q <= cfg_data[TL_W-1:0];
					REG_DEAD_BAND:     db_q <= cfg_data[DB_W-1:0];
					REG_MAX_DEVIATION: md_q <= cfg_data[MD_W-1:0];
					default: begin
					end
				endcase
			end

			if (wr_en) begin
				wr_cnt_q <= wr_cnt_q + CNT_W'(1);
				if (wr_cnt_q[ADDR_W-1:0] == '1) begin
					full_q <= 1'b1;
				end
			end

			// Block start: clear count, latch resync; on resync go target lag behind writer, start fade
			if (state_q == S_FILL) begin
				sample_cnt_q <= '0;
				resync_q     <= resync_c;
				if (resync_c) begin
					rd_cnt_q    <= wr_cnt_q - {{(CNT_W-TL_W){1'b0}}, tl_q};
					rd_frac_q   <= '0;
					fade_from_q <= last_out_q;
					fade_rem_q  <= FADE_INIT;
				end
			end

			// Advance the read position by the step
			if (state_q == S_MUL) begin
				rd_cnt_q  <= rd_cnt_q + {{(CNT_W-2){1'b0}}, frac_sum_c[FRAC_W+1:FRAC_W]};
				rd_frac_q <= frac_sum_c[FRAC_W-1:0];
			end

			if (state_q == S_INTERP) begin
				last_out_q <= interp_c[SAMPLE_W-1:0];
			end

			if (state_q == S_F5) begin
				fade_rem_q <= fade_rem_q - FADE_W'(1);
			end

			if (out_load) begin
				out_valid_q  <= 1'b1;
				sample_cnt_q <= sample_cnt_q + BLK_W'(1);
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_FILL: dev_q <= resync_c ? '0 : fill_dev_c;
			S_STEP: step_q <= step_c[STEP_W-1:0];
			S_RD_A: begin
				if (!ahead_ok_c) begin
					m_q     <= $signed({last_out_q[SAMPLE_W-1], last_out_q});
					under_q <= 1'b1;
				end
			end
			S_RD_B: a_q <= rd_ok_q ? rd_data_q : '0;
			S_INTERP: begin
				m_q     <= interp_c;
				under_q <= 1'b0;
			end
			S_F2: acc_q <= $signed(prod_q[ACC_W-1:0]);
			S_F3: begin
				neg_q  <= mix_c[ACC_W-1];
				absx_q <= mix_c[ACC_W-1] ? ACC_W'(-mix_c) : ACC_W'(mix_c);
			end
			S_F5: m_q <= neg_q ? -$signed(quot_c) : $signed(quot_c);
			default: begin
			end
		endcase
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q <= sat_c;
			out_under_q  <= under_q;
			out_resync_q <= resync_q;
			out_last_q   <= out_last_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_sample_q;
	assign m_axis_tuser  = {out_resync_q, out_under_q};
	assign m_axis_tlast  = out_last_q;

	`AER_ASSERT_NEXT(a_full_sticky, full_q, full_q, "ring full mark dropped")
	`AER_ASSERT_NEXT(a_rd_pos_hold, (state_q != S_MUL) && (state_q != S_FILL), $stable(rd_frac_q) && $stable(rd_cnt_q), "read position moved outside a step")
	`AER_ASSERT_NEXT(a_block_end, out_load && out_last_c, state_q == S_IDLE, "sequencer ran past the block end")
	`AER_ASSERT_SAME(a_fade_weight, state_q == S_F5, fade_rem_q != '0, "crossfade step with no weight left")

endmodule
